// ===== hdl/jfe_pkg.sv =====
// Shared types, character codes and helpers for the JSON field extractor.
package jfe_pkg;

  localparam int JFE_KEY_MAX_BYTES = 16;
  localparam int JFE_OUT_TDATA_W   = 48;
  localparam int JFE_CFG_ADDR_W    = 5;
  localparam int JFE_CFG_DATA_W    = 64;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR_MAX = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [1:0] REG_KEY_LO = 2'd0;
  localparam logic [1:0] REG_KEY_HI = 2'd1;
  localparam logic [1:0] REG_KEY_LEN = 2'd2;
  localparam logic [1:0] REG_KIND   = 2'd3;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NO_KEY   = 3'd1,
    ST_NO_COLON = 3'd2,
    ST_BAD_FORM = 3'd3,
    ST_UNTERM   = 3'd4
  } jfe_status_t;

  // Window control from the parser to the key matcher.
  typedef struct packed {
    logic shift;
    logic clear;
  } jfe_win_ctl_t;

  // Key character idx of the 16-character key; characters past 16 read as zero.
  function automatic logic [7:0] key_char(input logic [63:0] lo, input logic [63:0] hi,
                                          input int idx);
    logic [2:0] sel;
    logic [7:0] ch;
    sel = idx[2:0];
    if (idx < 8) begin
      ch = lo[{sel, 3'b000} +: 8];
    end else if (idx < 16) begin
      ch = hi[{sel, 3'b000} +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

// ===== hdl/jfe_needle_match.sv =====
// Sliding byte window and quoted-key comparator for the JSON field extractor.
module jfe_needle_match import jfe_pkg::*; #(
  parameter int KEY_MAX_BYTES = JFE_KEY_MAX_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  jfe_win_ctl_t ctl,
  input  logic [7:0]   byte_in,
  input  logic [63:0]  key_lo,
  input  logic [63:0]  key_hi,
  input  logic [4:0]   key_len,
  output logic         match
);

  localparam int WIN    = KEY_MAX_BYTES + 2;
  localparam int SEEN_W = $clog2(WIN + 1);

  logic [7:0]        win_r   [WIN];
  logic [7:0]        win_nxt [WIN];
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;

  // Window as it stands once the current byte is shifted in.
  always_comb begin
    for (int w = 0; w < WIN - 1; w++) begin
      win_nxt[w] = win_r[w + 1];
    end
    win_nxt[WIN-1] = byte_in;
    if (int'(seen_r) >= WIN) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + SEEN_W'(1);
    end
  end

  // Quote, key, quote aligned to the newest end of the window.
  always_comb begin
    int klen;
    int nlen;
    int ofs;
    logic [7:0] want;
    klen = int'(key_len);
    if (klen > KEY_MAX_BYTES) begin
      klen = KEY_MAX_BYTES;
    end
    nlen  = klen + 2;
    match = (int'(seen_nxt) >= nlen);
    for (int w = 0; w < WIN; w++) begin
      ofs = w + nlen - WIN;
      if (ofs == 0 || ofs == nlen - 1) begin
        want = CH_QUOTE;
      end else begin
        want = key_char(key_lo, key_hi, ofs - 1);
      end
      if (ofs >= 0 && win_nxt[w] != want) begin
        match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int w = 0; w < WIN; w++) begin
        win_r[w] <= 8'h00;
      end
      seen_r <= '0;
    end else if (ctl.shift) begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== hdl/json_field_extractor_unit.sv =====
// Top level of the JSON field extractor: registers, stream ports and value parser.
//
// Feed a JSON body on in_ one byte per item: in_tdata[7:0] is the byte and
// in_tlast marks the final byte of the body. The block looks for the first
// quoted key set in the key registers, the first colon after it, skips
// whitespace and then decodes the value. In string mode every decoded value
// character leaves as one item on out_ with out_tuser high; the body then ends
// with one item carrying out_tlast and a status. In integer mode only the
// final item is sent, with the parsed number. A status other than found means
// any characters already sent are to be discarded by the receiver.
// An accepted item waits in the input register; its result is registered in
// the output register, which drives out_. One byte is accepted every clock
// unless a result is held back by a waiting item; the path from the input
// register through the key window compare and the x10 accumulate is
// combinational. When out_tready is low the output register holds its item
// and the input register still takes one more byte; bytes that give no
// result keep flowing. rst_n (synchronous) clears the registers, the window
// and the parse state; state also returns to key search after each byte
// marked with in_tlast. Program registers only while the stream is idle.
module json_field_extractor_unit import jfe_pkg::*; #(
  parameter int KEY_MAX_BYTES = JFE_KEY_MAX_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // body_byte [7:0]
  input  logic [7:0]                 in_tdata,
  input  logic                       in_tlast,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // value_byte [7:0], number [39:8], status [42:40], zero fill [47:43]
  output logic [JFE_OUT_TDATA_W-1:0] out_tdata,
  // byte_valid [0]
  output logic                       out_tuser,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [JFE_CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [JFE_CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [JFE_CFG_DATA_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [2:0] {
    PH_KEY, PH_COLON, PH_SPACE, PH_STR, PH_ESC, PH_SIGN, PH_DIGITS, PH_IDLE
  } phase_t;

  // Configuration registers
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;
  logic [4:0]  key_len_r;
  logic        kind_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // Input register
  logic        stg_valid_r;
  logic [7:0]  stg_byte_r;
  logic        stg_last_r;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic        minus_r, minus_nxt;
  logic [31:0] acc_r, acc_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_char_valid_r;
  logic [31:0] out_num_r;
  logic        out_done_r;
  jfe_status_t out_status_r;

  // Result of the current byte
  logic        res_valid;
  logic [7:0]  res_char;
  logic        res_char_valid;
  logic [31:0] res_num;
  logic        res_done;
  jfe_status_t res_status;

  logic         adv;
  logic         match;
  jfe_win_ctl_t win_ctl;

  logic        is_space;
  logic        is_digit;
  logic [31:0] digit;
  logic [31:0] acc_mul;
  logic [31:0] num_first;
  logic [31:0] num_more;
  logic [31:0] num_cur;
  logic [7:0]  esc_char;

  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LO:  cfg_prdata = key_lo_r;
      REG_KEY_HI:  cfg_prdata = key_hi_r;
      REG_KEY_LEN: cfg_prdata = {59'd0, key_len_r};
      REG_KIND:    cfg_prdata = {63'd0, kind_r};
    endcase
  end

  // Advance the input register unless its result would overwrite a waiting item.
  assign adv       = stg_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || adv;

  assign win_ctl.shift = adv && (phase_r == PH_KEY);
  assign win_ctl.clear = adv && stg_last_r;

  jfe_needle_match #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_needle (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .byte_in (stg_byte_r),
    .key_lo  (key_lo_r),
    .key_hi  (key_hi_r),
    .key_len (key_len_r),
    .match   (match)
  );

  // Character classes and arithmetic on the held byte
  assign is_space  = (stg_byte_r == CH_SPACE) ||
                     (stg_byte_r >= CH_TAB && stg_byte_r <= CH_CR_MAX);
  assign is_digit  = (stg_byte_r >= CH_ZERO) && (stg_byte_r <= CH_NINE);
  assign digit     = {28'd0, 4'(stg_byte_r - CH_ZERO)};
  assign acc_mul   = (acc_r << 3) + (acc_r << 1) + digit;
  assign num_first = minus_r ? (32'd0 - digit) : digit;
  assign num_more  = minus_r ? (32'd0 - acc_mul) : acc_mul;
  assign num_cur   = minus_r ? (32'd0 - acc_r) : acc_r;

  always_comb begin
    priority if (stg_byte_r == CH_LOW_N) begin
      esc_char = CH_LF;
    end else if (stg_byte_r == CH_LOW_R) begin
      esc_char = CH_CR;
    end else if (stg_byte_r == CH_LOW_T) begin
      esc_char = CH_TAB;
    end else begin
      esc_char = stg_byte_r;
    end
  end

  // Parse step for one byte
  always_comb begin
    phase_nxt      = phase_r;
    minus_nxt      = minus_r;
    acc_nxt        = acc_r;
    res_valid      = 1'b0;
    res_char       = 8'h00;
    res_char_valid = 1'b0;
    res_num        = 32'd0;
    res_done       = 1'b0;
    res_status     = ST_FOUND;

    unique case (phase_r)
      PH_KEY: begin
        if (match) begin
          phase_nxt = PH_COLON;
        end
        if (stg_last_r) begin
          res_done   = 1'b1;
          res_status = match ? ST_NO_COLON : ST_NO_KEY;
        end
      end
      PH_COLON: begin
        if (stg_byte_r == CH_COLON) begin
          phase_nxt = PH_SPACE;
        end
        if (stg_last_r) begin
          res_done   = 1'b1;
          res_status = (stg_byte_r == CH_COLON) ? ST_BAD_FORM : ST_NO_COLON;
        end
      end
      PH_SPACE: begin
        if (is_space) begin
          if (stg_last_r) begin
            res_done   = 1'b1;
            res_status = ST_BAD_FORM;
          end
        end else if (!kind_r) begin
          if (stg_byte_r == CH_QUOTE && !stg_last_r) begin
            phase_nxt = PH_STR;
          end else begin
            res_done   = 1'b1;
            res_status = (stg_byte_r == CH_QUOTE) ? ST_UNTERM : ST_BAD_FORM;
          end
        end else if (stg_byte_r == CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = PH_SIGN;
          if (stg_last_r) begin
            res_done   = 1'b1;
            res_status = ST_BAD_FORM;
          end
        end else if (is_digit) begin
          acc_nxt   = digit;
          phase_nxt = PH_DIGITS;
          if (stg_last_r) begin
            res_done = 1'b1;
            res_num  = num_first;
          end
        end else begin
          res_done   = 1'b1;
          res_status = ST_BAD_FORM;
        end
      end
      PH_STR: begin
        if (stg_byte_r == CH_QUOTE) begin
          res_done = 1'b1;
        end else if (stg_last_r) begin
          res_done   = 1'b1;
          res_status = ST_UNTERM;
        end else if (stg_byte_r == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          res_char_valid = 1'b1;
          res_char       = stg_byte_r;
        end
      end
      PH_ESC: begin
        if (stg_last_r) begin
          res_done   = 1'b1;
          res_status = ST_UNTERM;
        end else begin
          phase_nxt      = PH_STR;
          res_char_valid = 1'b1;
          res_char       = esc_char;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          acc_nxt   = digit;
          phase_nxt = PH_DIGITS;
          if (stg_last_r) begin
            res_done = 1'b1;
            res_num  = num_first;
          end
        end else begin
          res_done   = 1'b1;
          res_status = ST_BAD_FORM;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_nxt = acc_mul;
          if (stg_last_r) begin
            res_done = 1'b1;
            res_num  = num_more;
          end
        end else begin
          res_done = 1'b1;
          res_num  = num_cur;
        end
      end
      PH_IDLE: begin
      end
    endcase

    res_valid = res_done || res_char_valid;
    if (res_done) begin
      phase_nxt = PH_IDLE;
    end
    // Drop all parse state at the end of a body
    if (stg_last_r) begin
      phase_nxt = PH_KEY;
      minus_nxt = 1'b0;
      acc_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r    <= 64'd0;
      key_hi_r    <= 64'd0;
      key_len_r   <= 5'd0;
      kind_r      <= 1'b0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_KEY;
      minus_r     <= 1'b0;
      acc_r       <= 32'd0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_KEY_LO:  key_lo_r  <= cfg_pwdata;
          REG_KEY_HI:  key_hi_r  <= cfg_pwdata;
          REG_KEY_LEN: key_len_r <= cfg_pwdata[4:0];
          REG_KIND:    kind_r    <= cfg_pwdata[0];
        endcase
      end

      if (in_tvalid && in_tready) begin
        stg_valid_r <= 1'b1;
        stg_byte_r  <= in_tdata;
        stg_last_r  <= in_tlast;
      end else if (adv) begin
        stg_valid_r <= 1'b0;
      end

      if (adv) begin
        phase_r <= phase_nxt;
        minus_r <= minus_nxt;
        acc_r   <= acc_nxt;
      end

      if (adv && res_valid) begin
        out_valid_r      <= 1'b1;
        out_char_r       <= res_char;
        out_char_valid_r <= res_char_valid;
        out_num_r        <= res_num;
        out_done_r       <= res_done;
        out_status_r     <= res_status;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_num_r, out_char_r};
  assign out_tuser  = out_char_valid_r;
  assign out_tlast  = out_done_r;

`ifndef ASSERT_OFF
  a_char_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_char_valid_r && out_done_r))
    else $error("character item also marked final");

  a_last_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stg_last_r |=> phase_r == PH_KEY)
    else $error("parse state not returned to key search after body end");

  a_char_from_string: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_char_valid |-> (phase_r == PH_STR || phase_r == PH_ESC))
    else $error("character item outside a string value");

  a_stage_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !adv |-> !(in_tvalid && in_tready))
    else $error("input register overwritten while held");

  a_minus_in_number: assert property (@(posedge clk) disable iff (!rst_n)
    minus_r |-> (phase_r == PH_SIGN || phase_r == PH_DIGITS || phase_r == PH_IDLE))
    else $error("minus flag set outside number parse");
`endif

endmodule

// ===== sim/jfe_checker.sv =====
// Checker for the JSON field extractor: mirrors the registers, predicts each result and compares.
module jfe_checker import jfe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 in_tdata,
  input  logic                       in_tlast,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [JFE_OUT_TDATA_W-1:0] out_tdata,
  input  logic                       out_tuser,
  input  logic                       out_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [JFE_CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [JFE_CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic                       cfg_pready,
  output int unsigned                mismatch_count,
  output int unsigned                open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = JFE_KEY_MAX_BYTES + 2;

  typedef enum logic [2:0] {
    SEEK_KEY, SEEK_COLON, SKIP_WS, IN_STRING, IN_ESCAPE, AFTER_MINUS, IN_DIGITS, BODY_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        ch_valid;
    logic [31:0] number;
    logic        done;
    jfe_status_t st;
  } extract_result_t;

  // register mirror
  logic [127:0] key_chars;
  logic [4:0]   key_len;
  logic         want_number;

  // parse state
  logic [7:0]   window [WINDOW];
  int           window_fill;
  parse_phase_t phase;
  logic         minus_seen;
  logic [31:0]  accum;

  extract_result_t result_q [$];

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR_MAX);
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_parse();
    foreach (window[k]) window[k] = 8'h00;
    window_fill = 0;
    phase       = SEEK_KEY;
    minus_seen  = 1'b0;
    accum       = '0;
  endfunction

  // quote, key (at most 16 characters), quote: at the tail of the window
  function automatic bit needle_seen();
    int         klen, nlen;
    logic [7:0] want;
    klen = (key_len > JFE_KEY_MAX_BYTES) ? JFE_KEY_MAX_BYTES : int'(key_len);
    nlen = klen + 2;
    if (window_fill < nlen) return 1'b0;
    for (int j = 0; j < nlen; j++) begin
      if (j == 0 || j == nlen - 1) want = CH_QUOTE;
      else want = key_chars[8*(j-1) +: 8];
      if (window[WINDOW - nlen + j] != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] signed_number();
    return minus_seen ? 32'd0 - accum : accum;
  endfunction

  function automatic extract_result_t end_body(input jfe_status_t st, input logic [31:0] num);
    extract_result_t r;
    r        = '0;
    r.number = num;
    r.done   = 1'b1;
    r.st     = st;
    phase    = BODY_DONE;
    return r;
  endfunction

  function automatic bit predict_byte(input logic [7:0] c, input logic last,
                                      output extract_result_t r);
    bit         has;
    logic [7:0] d;
    has = 1'b0;
    r   = '0;
    case (phase)
      SEEK_KEY: begin
        for (int k = 0; k < WINDOW - 1; k++) window[k] = window[k + 1];
        window[WINDOW - 1] = c;
        if (window_fill < WINDOW) window_fill++;
        if (needle_seen()) phase = last ? BODY_DONE : SEEK_COLON;
        if (last) begin
          r   = end_body((phase == BODY_DONE) ? ST_NO_COLON : ST_NO_KEY, '0);
          has = 1'b1;
        end
      end
      SEEK_COLON: begin
        if (c == CH_COLON) phase = SKIP_WS;
        if (last) begin
          r   = end_body((phase == SKIP_WS) ? ST_BAD_FORM : ST_NO_COLON, '0);
          has = 1'b1;
        end
      end
      SKIP_WS: begin
        if (is_ws(c)) begin
          if (last) begin
            r   = end_body(ST_BAD_FORM, '0);
            has = 1'b1;
          end
        end else if (!want_number) begin
          if (c == CH_QUOTE && !last) begin
            phase = IN_STRING;
          end else begin
            r   = end_body((c == CH_QUOTE) ? ST_UNTERM : ST_BAD_FORM, '0);
            has = 1'b1;
          end
        end else if (c == CH_MINUS) begin
          minus_seen = 1'b1;
          phase      = AFTER_MINUS;
          if (last) begin
            r   = end_body(ST_BAD_FORM, '0);
            has = 1'b1;
          end
        end else if (is_dig(c)) begin
          accum = {24'd0, c - CH_ZERO};
          phase = IN_DIGITS;
          if (last) begin
            r   = end_body(ST_FOUND, signed_number());
            has = 1'b1;
          end
        end else begin
          r   = end_body(ST_BAD_FORM, '0);
          has = 1'b1;
        end
      end
      IN_STRING: begin
        if (c == CH_QUOTE) begin
          r   = end_body(ST_FOUND, '0);
          has = 1'b1;
        end else if (last) begin
          r   = end_body(ST_UNTERM, '0);
          has = 1'b1;
        end else if (c == CH_BSLASH) begin
          phase = IN_ESCAPE;
        end else begin
          r.ch       = c;
          r.ch_valid = 1'b1;
          has        = 1'b1;
        end
      end
      IN_ESCAPE: begin
        if (last) begin
          r   = end_body(ST_UNTERM, '0);
          has = 1'b1;
        end else begin
          case (c)
            CH_LOW_N: d = CH_LF;
            CH_LOW_R: d = CH_CR;
            CH_LOW_T: d = CH_TAB;
            default:  d = c;
          endcase
          phase      = IN_STRING;
          r.ch       = d;
          r.ch_valid = 1'b1;
          has        = 1'b1;
        end
      end
      AFTER_MINUS: begin
        if (is_dig(c)) begin
          accum = {24'd0, c - CH_ZERO};
          phase = IN_DIGITS;
          if (last) begin
            r   = end_body(ST_FOUND, signed_number());
            has = 1'b1;
          end
        end else begin
          r   = end_body(ST_BAD_FORM, '0);
          has = 1'b1;
        end
      end
      IN_DIGITS: begin
        if (is_dig(c)) begin
          accum = accum * 32'd10 + {24'd0, c - CH_ZERO};
          if (last) begin
            r   = end_body(ST_FOUND, signed_number());
            has = 1'b1;
          end
        end else begin
          r   = end_body(ST_FOUND, signed_number());
          has = 1'b1;
        end
      end
      default: ;
    endcase
    if (last) clear_parse();
    return has;
  endfunction

  function automatic string show(input extract_result_t r);
    return $sformatf("ch=%02h ch_valid=%0b number=%08h done=%0b st=%0d",
                     r.ch, r.ch_valid, r.number, r.done, int'(r.st));
  endfunction

  function automatic void log_mismatch(input string what);
    if (mismatch_count < 10) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    extract_result_t exp_r, got_r;
    bit              produced;
    if (!rst_n) begin
      key_chars   = '0;
      key_len     = '0;
      want_number = 1'b0;
      clear_parse();
      result_q.delete();
    end else begin
      // compare first: a result never belongs to an item taken at the same edge
      if (out_tvalid && out_tready) begin
        got_r.ch       = out_tdata[7:0];
        got_r.ch_valid = out_tuser;
        got_r.number   = out_tdata[39:8];
        got_r.done     = out_tlast;
        got_r.st       = jfe_status_t'(out_tdata[42:40]);
        if (result_q.size() == 0) begin
          log_mismatch({"unexpected result ", show(got_r)});
        end else begin
          exp_r = result_q.pop_front();
          if (got_r !== exp_r || out_tdata[JFE_OUT_TDATA_W-1:43] !== '0)
            log_mismatch($sformatf("expected %s, got %s fill=%0h", show(exp_r), show(got_r),
                                   out_tdata[JFE_OUT_TDATA_W-1:43]));
        end
      end
      if (in_tvalid && in_tready) begin
        produced = predict_byte(in_tdata, in_tlast, exp_r);
        if (produced) result_q.insert(result_q.size(), exp_r);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_KEY_LO:  key_chars[63:0]   = cfg_pwdata;
          REG_KEY_HI:  key_chars[127:64] = cfg_pwdata;
          REG_KEY_LEN: key_len           = cfg_pwdata[4:0];
          REG_KIND:    want_number       = cfg_pwdata[0];
          default: ;
        endcase
      end
    end
    open_count = result_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the JSON field extractor: clock, reset, body stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jfe_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned PHASE_ITEMS   = 60;    // random bytes per register setting
  localparam int unsigned SETTING_COUNT = 7;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic [7:0]                 in_tdata;
  logic                       in_tlast;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [JFE_OUT_TDATA_W-1:0] out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [JFE_CFG_ADDR_W-1:0]  cfg_paddr;
  logic [JFE_CFG_DATA_W-1:0]  cfg_pwdata;
  logic [JFE_CFG_DATA_W-1:0]  cfg_prdata;
  logic                       cfg_pready;

  int unsigned mismatch_count;
  int unsigned open_count;

  // current register values, kept so that bodies can carry the right key
  logic [127:0] cur_key;
  logic [4:0]   cur_len;
  logic         cur_kind;

  logic [7:0]   body_q [$];
  int unsigned  sent_items;
  bit           hold_off_req;
  int unsigned  quiet_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  json_field_extractor_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  jfe_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .open_count     (open_count)
  );

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Append one byte to the body under construction.
  function automatic void append_byte(input logic [7:0] c);
    body_q.insert(body_q.size(), c);
  endfunction

  // Printable byte that neither closes a string nor starts an escape.
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] rand_ws();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  function automatic logic [127:0] rand_key();
    logic [127:0] k;
    for (int i = 0; i < 16; i++)
      k[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                                : 8'($urandom_range(8'h61, 8'h7A));
    return k;
  endfunction

  function automatic int key_chars_used();
    return (cur_len > JFE_KEY_MAX_BYTES) ? JFE_KEY_MAX_BYTES : int'(cur_len);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void push_needle();
    append_byte(CH_QUOTE);
    for (int i = 0; i < key_chars_used(); i++) append_byte(cur_key[8*i +: 8]);
    append_byte(CH_QUOTE);
  endfunction

  // Append a quoted string value; return 1 when the body has to end right here.
  function automatic bit push_string_value();
    int unsigned n, r;
    append_byte(CH_QUOTE);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        append_byte(rand_plain());
      end else if (r < 17) begin
        append_byte(CH_BSLASH);
        case ($urandom_range(0, 5))
          0: append_byte(CH_LOW_N);
          1: append_byte(CH_LOW_R);
          2: append_byte(CH_LOW_T);
          3: append_byte(CH_QUOTE);
          4: append_byte(CH_BSLASH);
          default: append_byte(8'h2F);
        endcase
      end else if (r < 19) begin
        append_byte(CH_BSLASH);
        append_byte(8'($urandom_range(0, 255)));
      end else begin
        append_byte(8'($urandom_range(0, 255)));
      end
    end
    case ($urandom_range(0, 11))
      8: return 1'b1;                          // body ends inside the string
      9: begin                                 // lone backslash as the final byte
        append_byte(CH_BSLASH);
        return 1'b1;
      end
      10: begin                                // escape cut by the end of the body
        append_byte(CH_BSLASH);
        append_byte(rand_plain());
        return 1'b1;
      end
      default: begin
        append_byte(CH_QUOTE);
        return 1'b0;
      end
    endcase
  endfunction

  // Append an integer value; return 1 when the body has to end right after it.
  function automatic bit push_number_value();
    int unsigned nd;
    if ($urandom_range(0, 9) == 0) begin
      append_byte(8'($urandom_range(8'h61, 8'h7A)));
      return 1'b0;
    end
    if ($urandom_range(0, 2) == 0) append_byte(CH_MINUS);
    // long runs of digits wrap the accumulator
    nd = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (nd) append_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    if ($urandom_range(0, 3) == 0) return 1'b1;
    case ($urandom_range(0, 3))
      0: append_byte(8'h2C);
      1: append_byte(8'h7D);
      2: append_byte(CH_SPACE);
      default: append_byte(8'h2E);
    endcase
    return 1'b0;
  endfunction

  // Mostly well-formed objects with random content; the rest noise or broken.
  function automatic void build_random_body();
    bit          stop_here;
    int unsigned n;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 16)) append_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) begin
        push_needle();
        repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    append_byte(8'h7B);
    if ($urandom_range(0, 3) == 0) push_text("\"zz\":0,");
    if ($urandom_range(0, 5) == 0) begin
      // key prefix without its closing quote
      append_byte(CH_QUOTE);
      n = $urandom_range(0, key_chars_used());
      for (int i = 0; i < n; i++) append_byte(cur_key[8*i +: 8]);
      append_byte(8'h2C);
    end
    push_needle();
    repeat ($urandom_range(0, 2)) append_byte(rand_ws());
    if ($urandom_range(0, 9) != 0) append_byte(CH_COLON);
    repeat ($urandom_range(0, 2)) append_byte(rand_ws());
    if (($urandom_range(0, 9) == 0) != cur_kind) stop_here = push_number_value();
    else stop_here = push_string_value();
    if (!stop_here) begin
      // trailing bytes, a second needle among them now and then
      if ($urandom_range(0, 7) == 0) push_needle();
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
      append_byte(8'h7D);
    end
  endfunction

  // Offer one item and hold it until taken. Keep tvalid high across back-to-back items.
  task automatic send_byte(input logic [7:0] b, input logic l, input bit gapless);
    int unsigned gap;
    gap = gapless ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= b;
    in_tlast  <= l;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_body();
    bit gapless;
    gapless = ($urandom_range(0, 3) == 0);
    foreach (body_q[i]) send_byte(body_q[i], i == body_q.size() - 1, gapless);
    sent_items += body_q.size();
    body_q.delete();
  endtask

  // Drop valid and wait for every expected item, then let the input register drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access; psel stays high between back-to-back writes.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic program_key(input logic [127:0] k, input logic [4:0] len, input logic kind);
    wait_idle();
    write_reg(REG_KEY_LO, k[63:0]);
    write_reg(REG_KEY_HI, k[127:64]);
    write_reg(REG_KEY_LEN, 64'(len));
    write_reg(REG_KIND, 64'(kind));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_key  = k;
    cur_len  = len;
    cur_kind = kind;
  endtask

  // Receiver: ready stretches, random gaps, and one long hold-off on request.
  initial begin
    int unsigned hold_left, ready_left, stall_left;
    out_tready <= 1'b0;
    hold_left  = 0;
    ready_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (ready_left != 0) begin
        ready_left--;
        out_tready <= 1'b1;
      end else begin
        ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 6);
        stall_left = pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus: directed bodies, then random bodies under a series of register settings.
  initial begin
    int unsigned phase_start, bodies;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cur_key      = '0;
    cur_len      = '0;
    cur_kind     = 1'b0;
    sent_items   = 0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: empty key, so the needle is a pair of quotes; string mode.
    body_q = '{8'h00, 8'hFF};              // key never seen
    send_body();
    push_text("\"\"");                     // needle on the final byte: no colon
    send_body();
    push_text("\"\":");                    // colon on the final byte: no value
    send_body();
    push_text("\"\":\"\\nx");              // mapped escape, then body ends in the string
    send_body();

    // Integer mode: lone minus at the end, then a negative value cut by the end.
    program_key('0, 5'd0, 1'b1);
    push_text("\"\":-");
    send_body();
    push_text("\"\":-7");
    send_body();

    for (int ph = 0; ph < SETTING_COUNT; ph++) begin
      case (ph)
        0: program_key(rand_key(), 5'd2, 1'b0);
        1: program_key(rand_key(), 5'd16, 1'b1);
        // all-ones low half then all-zero high half; length beyond the key limit
        2: program_key({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 5'd31, 1'b0);
        3: program_key({64'hFFFF_FFFF_FFFF_FFFF, 64'(rand_key() >> 64)}, 5'd17, 1'b1);
        4: program_key(rand_key(), 5'd1, 1'b0);
        5: program_key(rand_key(), 5'd0, 1'b1);
        default: program_key(rand_key(), 5'd9, 1'b0);
      endcase
      if (ph == 0) begin
        // Long string while the receiver holds off: fill the block and stall its input.
        hold_off_req = 1'b1;
        append_byte(8'h7B);
        push_needle();
        append_byte(CH_COLON);
        append_byte(CH_QUOTE);
        repeat (40) append_byte(rand_plain());
        append_byte(CH_QUOTE);
        append_byte(8'h7D);
        send_body();
      end
      phase_start = sent_items;
      bodies      = 0;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        build_random_body();
        send_body();
        bodies++;
        // now and then hold the sender until every result is back
        if (bodies % 6 == 0) wait_idle();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== json_field_extractor_unit.f =====
hdl/jfe_pkg.sv
hdl/jfe_needle_match.sv
hdl/json_field_extractor_unit.sv
sim/jfe_checker.sv
sim/tb_top.sv
